// ===== rtl/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared constants and types of the cubic Bezier easing block.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int XW        = FRAC_BITS + 1;          // Q1.F unsigned
  localparam int YW        = FRAC_BITS + 3;          // Q.F signed control y
  localparam int W         = FRAC_BITS + 10;         // signed datapath width
  localparam int QW        = FRAC_BITS + 2;          // Newton quotient width
  localparam int NUMW      = 2 * FRAC_BITS + 3;      // dividend width
  localparam int TDW       = ((XW + 7) / 8) * 8;     // stream data width
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = YW;

  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] TWO_Q = QW'(2) << FRAC_BITS;

  localparam logic [CFG_IW-1:0] REG_CTRL1_X = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_CTRL1_Y = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_CTRL2_X = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_CTRL2_Y = CFG_IW'(3);

  typedef enum logic [3:0] {
    ST_IDLE, ST_C0, ST_C1, ST_C2, ST_C3, ST_D0, ST_D1, ST_D2, ST_DIV, ST_OUT
  } cbe_state_e;

  typedef enum logic [1:0] {
    MD_NEWTON, MD_BISECT, MD_FINAL
  } cbe_mode_e;

endpackage

// ===== rtl/cbe_mul.sv =====
// ----------------------------------------------------------------------------
// cbe_mul
// Shared fractional multiplier: v * s / ONE, sign-magnitude, rounded half
// away from zero, result registered.
// ----------------------------------------------------------------------------
module cbe_mul (
  input  logic                            clk_i,
  input  logic signed [cbe_pkg::W-1:0]    v_i,
  input  logic        [cbe_pkg::XW-1:0]   s_i,
  output logic signed [cbe_pkg::W-1:0]    p_o
);

  localparam int PW = cbe_pkg::W + cbe_pkg::XW;

  logic [cbe_pkg::W-1:0] mag;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         rnd;
  logic [cbe_pkg::W-1:0] res;
  logic signed [cbe_pkg::W-1:0] p_d, p_q;

  always_comb begin
    mag  = v_i[cbe_pkg::W-1] ? cbe_pkg::W'(-v_i) : cbe_pkg::W'(v_i);
    prod = PW'(mag) * PW'(s_i);
    rnd  = (prod + (PW'(1) << (cbe_pkg::FRAC_BITS - 1))) >> cbe_pkg::FRAC_BITS;
    res  = rnd[cbe_pkg::W-1:0];
    p_d  = v_i[cbe_pkg::W-1] ? -signed'(res) : signed'(res);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/cbe_div.sv =====
// ----------------------------------------------------------------------------
// cbe_div
// Restoring divider for the Newton quotient, one bit a cycle, saturated to
// two.
// ----------------------------------------------------------------------------
module cbe_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cbe_pkg::NUMW-1:0]       num_i,
  input  logic [cbe_pkg::W-1:0]          den_i,
  output logic                           done_o,
  output logic [cbe_pkg::QW-1:0]         quot_o
);

  localparam int CW = $clog2(cbe_pkg::QW + 1);

  logic                      busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [cbe_pkg::W-1:0]     rem_q, rem_d, den_q, den_d;
  logic [cbe_pkg::QW-1:0]    nlo_q, nlo_d, qacc_q, qacc_d;
  logic [cbe_pkg::W:0]       trial;
  logic [cbe_pkg::W:0]       diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nlo_d  = nlo_q;
    qacc_d = qacc_q;
    trial  = {rem_q, nlo_q[cbe_pkg::QW-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      den_d = den_i;
      if (cbe_pkg::W'(num_i[cbe_pkg::NUMW-1:cbe_pkg::QW]) >= den_i) begin
        // quotient far above two: saturate at once
        qacc_d = cbe_pkg::TWO_Q;
        done_d = 1'b1;
      end else begin
        rem_d  = cbe_pkg::W'(num_i[cbe_pkg::NUMW-1:cbe_pkg::QW]);
        nlo_d  = num_i[cbe_pkg::QW-1:0];
        qacc_d = '0;
        cnt_d  = CW'(cbe_pkg::QW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!diff[cbe_pkg::W]) begin
        rem_d  = diff[cbe_pkg::W-1:0];
        qacc_d = {qacc_q[cbe_pkg::QW-2:0], 1'b1};
      end else begin
        rem_d  = trial[cbe_pkg::W-1:0];
        qacc_d = {qacc_q[cbe_pkg::QW-2:0], 1'b0};
      end
      nlo_d = nlo_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    nlo_q  <= nlo_d;
    qacc_q <= qacc_d;
  end

  assign done_o = done_q;
  assign quot_o = (qacc_q > cbe_pkg::TWO_Q) ? cbe_pkg::TWO_Q : qacc_q;

endmodule

// ===== rtl/cubic_bezier_easing.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing
// Cubic Bezier easing curve: solves x(s) = t by Newton steps with bisection
// fallback and returns y(s) clamped to [0,1].
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                     Payload
//  s_axis   in         s_axis_tvalid_i/tready_o      progress t, Q1.16
//  m_axis   out        m_axis_tvalid_o/tready_i      eased_value, Q1.16
//  cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
//  One item at a time; ready is high only while idle with no result pending.
//  The default curve passes t straight to the output register. Otherwise each
//  Newton step evaluates x(s) and then its slope on the shared multiplier and
//  divides on the bit-serial divider; each bisection step and the final y
//  evaluation use the cubic states only. A stalled result holds in the output
//  register.
//  Reset is asynchronous, active low, and restores the linear curve.
//
module cubic_bezier_easing #(
  parameter int NEWTON_STEPS = 4,
  parameter int BISECT_STEPS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [cbe_pkg::TDW-1:0]       s_axis_tdata_i,   // [16:0] progress
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [cbe_pkg::TDW-1:0]       m_axis_tdata_o,   // [16:0] eased_value
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbe_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [cbe_pkg::CFG_DW-1:0]    cfg_data_i
);

  localparam int F   = cbe_pkg::FRAC_BITS;
  localparam int W   = cbe_pkg::W;
  localparam int XW  = cbe_pkg::XW;
  localparam int YW  = cbe_pkg::YW;
  localparam int NCW = (NEWTON_STEPS > 0) ? $clog2(NEWTON_STEPS + 1) : 1;
  localparam int BCW = $clog2(BISECT_STEPS + 1);
  localparam int SW  = F + 4;

  // configuration registers
  logic        [XW-1:0] c1x_q, c2x_q;
  logic signed [YW-1:0] c1y_q, c2y_q;
  logic        [XW-1:0] cfg_x;

  // sequencer state
  cbe_pkg::cbe_state_e state_q, state_d;
  cbe_pkg::cbe_mode_e  mode_q, mode_d;
  logic [NCW-1:0]      ncnt_q, ncnt_d;
  logic [BCW-1:0]      bcnt_q, bcnt_d;
  logic [XW-1:0]       t_q, t_d, s_q, s_d, lo_q, lo_d, hi_q, hi_d;
  logic signed [W-1:0] r_q, r_d;
  logic                d_neg_q, d_neg_d;
  logic                out_valid_q, out_valid_d;
  logic [XW-1:0]       out_q, out_d;

  // coefficients
  logic signed [W-1:0] ax, bx, cx, ay, by, cy, ca, cb, cc;
  logic signed [W-1:0] mul_v, p, t_s, r, d, absr, absd;
  logic [XW-1:0]       t_in, lo_n, hi_n, mid;
  logic [F+2:0]        mr;
  logic [cbe_pkg::NUMW-1:0] num;
  logic                div_start, div_done;
  logic [cbe_pkg::QW-1:0] quot;
  logic signed [SW-1:0] s_step;
  logic                 is_default;

  assign cfg_ready_o = 1'b1;
  assign cfg_x = (cfg_data_i[XW-1:0] > cbe_pkg::ONE_X) ? cbe_pkg::ONE_X
                                                        : cfg_data_i[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1x_q <= '0;
      c1y_q <= '0;
      c2x_q <= cbe_pkg::ONE_X;
      c2y_q <= YW'(cbe_pkg::ONE_X);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cbe_pkg::REG_CTRL1_X: c1x_q <= cfg_x;
        cbe_pkg::REG_CTRL1_Y: c1y_q <= signed'(cfg_data_i);
        cbe_pkg::REG_CTRL2_X: c2x_q <= cfg_x;
        cbe_pkg::REG_CTRL2_Y: c2y_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // polynomial coefficients; the user must keep them stable while an item is at work, the block does not enforce it
  always_comb begin
    cx = W'(3) * signed'(W'(c1x_q));
    bx = W'(3) * (signed'(W'(c2x_q)) - signed'(W'(c1x_q))) - cx;
    ax = signed'(W'(cbe_pkg::ONE_X)) - cx - bx;
    cy = W'(3) * W'(c1y_q);
    by = W'(3) * (W'(c2y_q) - W'(c1y_q)) - cy;
    ay = signed'(W'(cbe_pkg::ONE_X)) - cy - by;
  end

  assign is_default = (c1x_q == '0) && (c1y_q == '0) && (c2x_q == cbe_pkg::ONE_X)
                   && (c2y_q == YW'(cbe_pkg::ONE_X));

  cbe_mul u_mul (
    .clk_i (clk_i),
    .v_i   (mul_v),
    .s_i   (s_q),
    .p_o   (p)
  );

  cbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (absd),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    t_in = (s_axis_tdata_i[XW-1:0] > cbe_pkg::ONE_X) ? cbe_pkg::ONE_X
                                                     : s_axis_tdata_i[XW-1:0];
    ca = (mode_q == cbe_pkg::MD_FINAL) ? ay : ax;
    cb = (mode_q == cbe_pkg::MD_FINAL) ? by : bx;
    cc = (mode_q == cbe_pkg::MD_FINAL) ? cy : cx;
    t_s  = signed'(W'(t_q));
    r    = p - t_s;
    d    = p + cx;
    absr = r_q[W-1] ? -r_q : r_q;
    absd = d[W-1] ? -d : d;
    mr   = (absr > signed'(W'(4) << F)) ? ((F+3)'(4) << F) : absr[F+2:0];
    num  = (cbe_pkg::NUMW'(mr) << F) + cbe_pkg::NUMW'(absd >> 1);
    // bisection bounds from the current evaluation
    lo_n = (t_s > p) ? s_q : lo_q;
    hi_n = (t_s > p) ? hi_q : s_q;
    mid  = lo_n + ((hi_n - lo_n) >> 1);
    // Newton update: s plus or minus the quotient, clamped later to [0,1]
    if ((r_q[W-1]) != d_neg_q)
      s_step = signed'(SW'(s_q)) + signed'(SW'(quot));
    else
      s_step = signed'(SW'(s_q)) - signed'(SW'(quot));
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ncnt_d      = ncnt_q;
    bcnt_d      = bcnt_q;
    t_d         = t_q;
    s_d         = s_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    r_d         = r_q;
    d_neg_d     = d_neg_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mul_v       = '0;
    div_start   = 1'b0;
    s_axis_tready_o = (state_q == cbe_pkg::ST_IDLE) && !out_valid_q;

    case (state_q)
      cbe_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          t_d    = t_in;
          s_d    = t_in;
          ncnt_d = '0;
          bcnt_d = '0;
          lo_d   = '0;
          hi_d   = cbe_pkg::ONE_X;
          if (is_default) begin
            out_d       = t_in;
            out_valid_d = 1'b1;
          end else begin
            mode_d  = (NEWTON_STEPS > 0) ? cbe_pkg::MD_NEWTON : cbe_pkg::MD_BISECT;
            state_d = cbe_pkg::ST_C0;
          end
        end
      end
      // cubic: ((a*s + b)*s + c)*s
      cbe_pkg::ST_C0: begin
        mul_v   = ca;
        state_d = cbe_pkg::ST_C1;
      end
      cbe_pkg::ST_C1: begin
        mul_v   = p + cb;
        state_d = cbe_pkg::ST_C2;
      end
      cbe_pkg::ST_C2: begin
        mul_v   = p + cc;
        state_d = cbe_pkg::ST_C3;
      end
      cbe_pkg::ST_C3: begin
        case (mode_q)
          cbe_pkg::MD_NEWTON: begin
            r_d = r;
            if (r == '0) begin
              mode_d  = cbe_pkg::MD_FINAL;
              state_d = cbe_pkg::ST_C0;
            end else begin
              state_d = cbe_pkg::ST_D0;
            end
          end
          cbe_pkg::MD_BISECT: begin
            if (r == '0) begin
              mode_d  = cbe_pkg::MD_FINAL;
              state_d = cbe_pkg::ST_C0;
            end else begin
              lo_d   = lo_n;
              hi_d   = hi_n;
              s_d    = mid;
              bcnt_d = bcnt_q + BCW'(1);
              if ((bcnt_q == BCW'(BISECT_STEPS - 1)) || !(lo_n < hi_n))
                mode_d = cbe_pkg::MD_FINAL;
              state_d = cbe_pkg::ST_C0;
            end
          end
          default: begin
            // final y: clamp to [0,1] and hold for the output side
            if (p[W-1])
              out_d = '0;
            else if (p > signed'(W'(cbe_pkg::ONE_X)))
              out_d = cbe_pkg::ONE_X;
            else
              out_d = p[XW-1:0];
            out_valid_d = 1'b1;
            state_d     = cbe_pkg::ST_OUT;
          end
        endcase
      end
      // slope: (3a*s + 2b)*s + c
      cbe_pkg::ST_D0: begin
        mul_v   = W'(3) * ax;
        state_d = cbe_pkg::ST_D1;
      end
      cbe_pkg::ST_D1: begin
        mul_v   = p + (bx <<< 1);
        state_d = cbe_pkg::ST_D2;
      end
      cbe_pkg::ST_D2: begin
        if (d == '0) begin
          mode_d  = cbe_pkg::MD_FINAL;
          state_d = cbe_pkg::ST_C0;
        end else begin
          // hold the slope sign for the update after the divide
          d_neg_d   = d[W-1];
          div_start = 1'b1;
          state_d   = cbe_pkg::ST_DIV;
        end
      end
      cbe_pkg::ST_DIV: begin
        if (div_done) begin
          if (s_step < 0)
            s_d = '0;
          else if (s_step > signed'(SW'(cbe_pkg::ONE_X)))
            s_d = cbe_pkg::ONE_X;
          else
            s_d = s_step[XW-1:0];
          ncnt_d = ncnt_q + NCW'(1);
          if (ncnt_q == NCW'(NEWTON_STEPS - 1)) begin
            s_d    = t_q;
            mode_d = cbe_pkg::MD_BISECT;
          end
          state_d = cbe_pkg::ST_C0;
        end
      end
      cbe_pkg::ST_OUT: begin
        if (!out_valid_q)
          state_d = cbe_pkg::ST_IDLE;
      end
      default: state_d = cbe_pkg::ST_IDLE;
    endcase

    if (out_valid_q && m_axis_tready_i)
      out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbe_pkg::ST_IDLE;
      mode_q      <= cbe_pkg::MD_NEWTON;
      ncnt_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      ncnt_q      <= ncnt_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    s_q     <= s_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    r_q     <= r_d;
    d_neg_q <= d_neg_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = cbe_pkg::TDW'(out_q);

endmodule
